[rtl/dsch_pkg.sv]
`timescale 1ns / 1ps

package dsch_pkg;

    localparam logic [15:0] RESET_CYLINDERS = 16'd200;

    localparam logic [1:0] STAT_ACCEPTED = 2'd0;
    localparam logic [1:0] STAT_DROPPED  = 2'd1;
    localparam logic [1:0] STAT_MOVE     = 2'd2;
    localparam logic [1:0] STAT_EMPTY    = 2'd3;

    localparam logic [1:0] POL_FCFS = 2'd0;
    localparam logic [1:0] POL_SSTF = 2'd1;
    localparam logic [1:0] POL_SCAN = 2'd2;

    localparam logic [1:0] REG_CYL_COUNT  = 2'd0;
    localparam logic [1:0] REG_START_HEAD = 2'd1;
    localparam logic [1:0] REG_POLICY     = 2'd2;

    localparam logic ACT_SUBMIT = 1'b0;
    localparam logic ACT_RUN    = 1'b1;

    typedef struct packed {
        logic        action;
        logic [15:0] cylinder;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] from_cyl;
        logic [15:0] to_cyl;
        logic [15:0] seek_distance;
        logic [31:0] service_number;
        logic [21:0] total_seek;
        logic        last;
    } t_rsp;

endpackage

[rtl/dsch_req_if.sv]
`timescale 1ns / 1ps

interface dsch_req_if import dsch_pkg::*; ();
    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[rtl/dsch_rsp_if.sv]
`timescale 1ns / 1ps

interface dsch_rsp_if import dsch_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[rtl/disk_request_scheduler_top.sv]
`timescale 1ns / 1ps

// Disk head scheduler. Submit beats append a cylinder (clamped to the cylinder
// count minus one) to a queue held in a single-port synchronous memory, or
// drop it if the queue is full, and give one registered result. A run beat
// drains the queue in FCFS, shortest-seek or LOOK order, one head-move result
// per entry. Every pick scans the queue memory through its one read port, one
// entry per cycle; no new beat is taken until the run ends. A finished result
// sits in an output register, so a stalled sink only delays the next pick or
// submit. Configuration writes are expected only while idle.
module disk_request_scheduler_top import dsch_pkg::*; #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata,
    dsch_req_if.sink    i_req,
    dsch_rsp_if.source  o_rsp
);

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_state;

    function automatic logic [15:0] clamp_cyl(input logic [15:0] c, input logic [15:0] cnt);
        logic [15:0] top;
        top = cnt - 16'd1;
        return (c > top) ? top : c;
    endfunction

    t_state r_state;

    logic [15:0] r_cyl_count;
    logic [15:0] r_home_cyl;
    logic [1:0]  r_policy;
    logic [CW-1:0] r_count;
    logic [15:0] r_head;
    logic [31:0] r_served;
    logic [QUEUE_DEPTH-1:0] r_used;

    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_k;
    logic          r_rd_vld;
    logic [QW-1:0] r_rd_idx;
    logic [15:0]   r_rd_data;
    logic [15:0]   r_start;
    logic [21:0]   r_total;

    logic          r_p_found;
    logic [15:0]   r_p_val;
    logic [15:0]   r_p_key;
    logic [QW-1:0] r_p_idx;
    logic          r_s_found;
    logic [15:0]   r_s_val;
    logic [QW-1:0] r_s_idx;

    logic r_out_valid;
    t_rsp r_out;

    logic [15:0] mem [QUEUE_DEPTH];

    logic [15:0]   n_req_cyl;
    logic          n_out_free;
    logic          n_in_ready;
    logic          n_in_acc;
    logic          n_out_load;
    logic          n_full;
    logic          n_mem_we;
    logic          n_issue;
    logic [CW-1:0] n_last_idx;
    logic [15:0]   n_dist_head;
    logic          n_cand;
    logic          n_take_p;
    logic          n_take_s;
    logic          n_scan_done;
    logic [15:0]   n_pick_val;
    logic [QW-1:0] n_pick_idx;
    logic [15:0]   n_emit_dist;
    logic [21:0]   n_emit_total;
    logic          n_emit_last;
    logic [15:0]   n_cnt_wr;

    assign n_req_cyl  = clamp_cyl(i_req.payload.cylinder, r_cyl_count);
    assign n_out_free = !r_out_valid || o_rsp.ready;
    assign n_in_ready = (r_state == ST_IDLE) && n_out_free;
    assign n_in_acc   = i_req.valid && n_in_ready;
    assign n_out_load = ((r_state == ST_IDLE) && n_in_acc &&
                         ((i_req.payload.action == ACT_SUBMIT) || (r_count == '0))) ||
                        ((r_state == ST_EMIT) && n_out_free);
    assign n_full     = (r_count == CW'(QUEUE_DEPTH));
    assign n_mem_we   = n_in_acc && (i_req.payload.action == ACT_SUBMIT) && !n_full;
    assign n_issue    = (r_state == ST_SCAN) && (r_idx < r_count);
    assign n_last_idx = r_count - CW'(1);
    assign n_cnt_wr   = (i_cfg_wdata == 16'd0) ? 16'd1 : i_cfg_wdata;

    assign n_dist_head = (r_rd_data >= r_head) ? (r_rd_data - r_head) : (r_head - r_rd_data);
    assign n_cand      = r_rd_vld && !r_used[r_rd_idx];
    assign n_scan_done = r_rd_vld && (r_rd_idx == n_last_idx[QW-1:0]);

    always_comb begin
        n_take_p = 1'b0;
        n_take_s = 1'b0;
        case (r_policy)
            POL_FCFS: begin
                n_take_p = n_cand && !r_p_found;
            end
            POL_SSTF: begin
                n_take_p = n_cand && (!r_p_found || (n_dist_head < r_p_key));
            end
            default: begin
                if (r_rd_data >= r_start) begin
                    n_take_p = n_cand && (!r_p_found || (r_rd_data < r_p_val));
                end else begin
                    n_take_s = n_cand && (!r_s_found || (r_rd_data > r_s_val));
                end
            end
        endcase
    end

    assign n_pick_val   = r_p_found ? r_p_val : r_s_val;
    assign n_pick_idx   = r_p_found ? r_p_idx : r_s_idx;
    assign n_emit_dist  = (n_pick_val >= r_head) ? (n_pick_val - r_head) : (r_head - n_pick_val);
    assign n_emit_total = r_total + {6'd0, n_emit_dist};
    assign n_emit_last  = (r_k == n_last_idx);

    assign i_req.ready   = n_in_ready;
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (n_mem_we) begin
            mem[r_count[QW-1:0]] <= n_req_cyl;
        end
        if (n_issue) begin
            r_rd_data <= mem[r_idx[QW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cyl_count  <= RESET_CYLINDERS;
            r_home_cyl   <= 16'd0;
            r_policy     <= POL_FCFS;
            r_count      <= '0;
            r_head       <= 16'd0;
            r_served     <= 32'd0;
            r_used       <= '0;
            r_idx        <= '0;
            r_k          <= '0;
            r_rd_vld     <= 1'b0;
            r_p_found    <= 1'b0;
            r_s_found    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (n_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            r_rd_vld <= n_issue;
            r_rd_idx <= r_idx[QW-1:0];

            case (r_state)
                ST_IDLE: begin
                    if (n_in_acc) begin
                        r_out.from_cyl       <= r_head;
                        r_out.seek_distance  <= 16'd0;
                        r_out.service_number <= 32'd0;
                        r_out.total_seek     <= 22'd0;
                        r_out.last           <= 1'b1;
                        if (i_req.payload.action == ACT_SUBMIT) begin
                            r_out.to_cyl <= n_req_cyl;
                            if (n_full) begin
                                r_out.status <= STAT_DROPPED;
                            end else begin
                                r_out.status <= STAT_ACCEPTED;
                                r_count      <= r_count + CW'(1);
                            end
                        end else if (r_count == '0) begin
                            r_out.status <= STAT_EMPTY;
                            r_out.to_cyl <= r_head;
                        end else begin
                            r_start     <= r_head;
                            r_total     <= 22'd0;
                            r_k         <= '0;
                            r_idx       <= '0;
                            r_p_found   <= 1'b0;
                            r_s_found   <= 1'b0;
                            r_state     <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (n_issue) begin
                        r_idx <= r_idx + CW'(1);
                    end
                    if (n_take_p) begin
                        r_p_found <= 1'b1;
                        r_p_val   <= r_rd_data;
                        r_p_key   <= n_dist_head;
                        r_p_idx   <= r_rd_idx;
                    end
                    if (n_take_s) begin
                        r_s_found <= 1'b1;
                        r_s_val   <= r_rd_data;
                        r_s_idx   <= r_rd_idx;
                    end
                    if (n_scan_done) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (n_out_free) begin
                        r_out.status         <= STAT_MOVE;
                        r_out.from_cyl       <= r_head;
                        r_out.to_cyl         <= n_pick_val;
                        r_out.seek_distance  <= n_emit_dist;
                        r_out.service_number <= r_served;
                        r_out.total_seek     <= n_emit_total;
                        r_out.last           <= n_emit_last;
                        r_head               <= n_pick_val;
                        r_total              <= n_emit_total;
                        r_served             <= r_served + 32'd1;
                        r_p_found            <= 1'b0;
                        r_s_found            <= 1'b0;
                        r_idx                <= '0;
                        if (n_emit_last) begin
                            r_count <= '0;
                            r_used  <= '0;
                            r_state <= ST_IDLE;
                        end else begin
                            r_used[n_pick_idx] <= 1'b1;
                            r_k                <= r_k + CW'(1);
                            r_state            <= ST_SCAN;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_CYL_COUNT: begin
                        r_cyl_count <= n_cnt_wr;
                        r_count     <= '0;
                        r_served    <= 32'd0;
                        r_head      <= clamp_cyl(r_home_cyl, n_cnt_wr);
                    end
                    REG_START_HEAD: begin
                        r_home_cyl <= i_cfg_wdata;
                        r_head     <= clamp_cyl(i_cfg_wdata, r_cyl_count);
                    end
                    REG_POLICY: begin
                        r_policy <= i_cfg_wdata[1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

[rtl/dsch_checker.sv]
`timescale 1ns / 1ps

module dsch_checker import dsch_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_rsp_valid,
    input logic i_rsp_ready,
    input t_rsp i_rsp_data
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_data))
        else $error("result beat dropped or changed while stalled");

    a_move_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_data.status == STAT_MOVE) |->
        ((i_rsp_data.to_cyl >= i_rsp_data.from_cyl) ?
            (i_rsp_data.seek_distance == i_rsp_data.to_cyl - i_rsp_data.from_cyl) :
            (i_rsp_data.seek_distance == i_rsp_data.from_cyl - i_rsp_data.to_cyl)))
        else $error("seek distance does not match move");

    a_move_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_data.status == STAT_MOVE) |->
        (i_rsp_data.total_seek >= {6'd0, i_rsp_data.seek_distance}))
        else $error("running total below this move's distance");

    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_data.status != STAT_MOVE) |->
        i_rsp_data.last && (i_rsp_data.seek_distance == 16'd0) &&
        (i_rsp_data.service_number == 32'd0) && (i_rsp_data.total_seek == 22'd0))
        else $error("non-move result carries move data");

endmodule

bind disk_request_scheduler_top dsch_checker u_dsch_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.payload)
);
